/* src/kway_sorted_run_merge_core_assert.svh */
// Assertion macros for the k-way sorted run merge core.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef KWAY_SORTED_RUN_MERGE_CORE_ASSERT_SVH
`define KWAY_SORTED_RUN_MERGE_CORE_ASSERT_SVH

// Condition and consequence in the same cycle.
`define KWSRM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwsrm: same-cycle check failed");

// Consequence in the cycle after the condition.
`define KWSRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwsrm: next-cycle check failed");

`endif

/* src/kwsrm_pkg.sv */
// Package of the k-way sorted run merge core: sizes, codes, state types
// and small helper functions. Depends on nothing.
`default_nettype none

package kwsrm_pkg;

  localparam int LANES       = 8;
  localparam int KEY_BYTES   = 8;
  localparam int VALUE_BYTES = 8;

  localparam int LANE_W = $clog2(LANES);
  localparam int KEY_W  = 8 * KEY_BYTES;
  localparam int VAL_W  = 8 * VALUE_BYTES;
  localparam int CNT_W  = $clog2(LANES + 1);

  localparam int LANE_FW = 3;
  localparam int KEY_FW  = 64;
  localparam int VAL_FW  = 64;
  localparam int MASK_FW = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    LS_HEAD  = 2'd0,
    LS_WAIT  = 2'd1,
    LS_ENDED = 2'd2
  } lane_st_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  function automatic logic [MASK_FW-1:0] refill_view(input logic [LANES-1:0] m);
    logic [MASK_FW-1:0] r;
    r = '0;
    for (int i = 0; i < LANES && i < MASK_FW; i++) begin
      r[i] = m[i];
    end
    return r;
  endfunction

  function automatic logic [LANE_W-1:0] lowest_set(input logic [LANES-1:0] v);
    logic [LANE_W-1:0] r;
    r = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = LANE_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/kwsrm_ifc.sv */
// Valid/ready channel interfaces of the merge core: record input,
// result output and mode write. Depends on kwsrm_pkg.
`default_nettype none

interface kwsrm_in_if;
  logic                           valid;
  logic                           ready;
  logic [kwsrm_pkg::LANE_FW-1:0]  lane;
  logic [kwsrm_pkg::KEY_FW-1:0]   rec_key;
  logic [kwsrm_pkg::VAL_FW-1:0]   rec_value;
  logic                           run_ended;
  modport source (output valid, lane, rec_key, rec_value, run_ended, input ready);
  modport sink   (input valid, lane, rec_key, rec_value, run_ended, output ready);
endinterface

interface kwsrm_out_if;
  logic                           valid;
  logic                           ready;
  logic [kwsrm_pkg::KEY_FW-1:0]   out_key;
  logic [kwsrm_pkg::VAL_FW-1:0]   out_value;
  logic [kwsrm_pkg::LANE_FW-1:0]  source_lane;
  logic                           last_of_group;
  logic [kwsrm_pkg::MASK_FW-1:0]  refill_mask;
  logic                           all_done;
  modport source (output valid, out_key, out_value, source_lane, last_of_group,
                  refill_mask, all_done, input ready);
  modport sink   (input valid, out_key, out_value, source_lane, last_of_group,
                  refill_mask, all_done, output ready);
endinterface

interface kwsrm_cfg_if;
  logic valid;
  logic ready;
  logic merge_mode;
  modport source (output valid, merge_mode, input ready);
  modport sink   (input valid, merge_mode, output ready);
endinterface

`default_nettype wire

/* src/kwsrm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the head records of the merge core. No dependencies.
`default_nettype none

module kwsrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* src/kwsrm_cmp.sv */
// Shared unsigned key comparator of the merge core, used once per lane
// during the least-key scan. Depends on kwsrm_pkg.
`default_nettype none

module kwsrm_cmp (
  input  wire logic [kwsrm_pkg::KEY_W-1:0] key,
  input  wire logic [kwsrm_pkg::KEY_W-1:0] least,
  output kwsrm_pkg::cmp_res_t              res
);

  assign res.lt = key < least;
  assign res.eq = key == least;

endmodule

`default_nettype wire

/* src/kway_sorted_run_merge_core.sv */
// Top level of the k-way sorted run merge core: lane status, sequencer,
// output register. Depends on kwsrm_pkg, kwsrm_ifc, kwsrm_ram, kwsrm_cmp.
//
// Usage: in_bus carries one beat per record or end-of-run mark for a lane.
// cfg_bus writes merge_mode (0 group, 1 single); write it only while idle.
// out_bus carries result beats from a single output register.
// An input beat that leaves some live lane waiting yields nothing. A beat
// that fills the last waiting lane starts a scan of the head memory
// through one shared comparator, a memory read and a compare per lane,
// then each result takes a memory read and an output load. A beat that
// ends the last live lane moves the sequencer to its done state, which
// loads the done beat once the output register frees. in_bus.ready is
// high only while the sequencer is idle. When out_bus stalls, the
// sequencer holds its pending result until the output register frees.
// After the done beat, further beats are accepted and ignored until
// reset. Reset (rst_n, synchronous) marks all lanes waiting, clears
// counters, done flag and merge_mode; head records need no clearing.
`default_nettype none
`include "kway_sorted_run_merge_core_assert.svh"

module kway_sorted_run_merge_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  kwsrm_in_if.sink    in_bus,
  kwsrm_cfg_if.sink   cfg_bus,
  kwsrm_out_if.source out_bus
);

  localparam int LANES  = kwsrm_pkg::LANES;
  localparam int LANE_W = kwsrm_pkg::LANE_W;
  localparam int KEY_W  = kwsrm_pkg::KEY_W;
  localparam int VAL_W  = kwsrm_pkg::VAL_W;
  localparam int CNT_W  = kwsrm_pkg::CNT_W;
  localparam int KFW    = kwsrm_pkg::KEY_FW;
  localparam int VFW    = kwsrm_pkg::VAL_FW;
  localparam int LFW    = kwsrm_pkg::LANE_FW;
  localparam int RAM_W  = KEY_W + VAL_W;

  kwsrm_pkg::state_t   state_r, state_nxt;
  kwsrm_pkg::lane_st_t status_r [LANES];
  kwsrm_pkg::lane_st_t status_nxt [LANES];

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic              mode_r;
  logic [LANE_W-1:0] scan_idx_r, scan_idx_nxt;
  logic              have_r, have_nxt;
  logic [KEY_W-1:0]  least_r, least_nxt;
  logic [LANE_W-1:0] pick_r, pick_nxt;
  logic [LANES-1:0]  match_r, match_nxt;
  logic [LANES-1:0]  rem_r, rem_nxt;
  logic [LANE_W-1:0] emit_lane_r, emit_lane_nxt;
  logic              emit_last_r, emit_last_nxt;

  logic              out_valid_r;
  logic [KFW-1:0]    out_key_r;
  logic [VFW-1:0]    out_value_r;
  logic [LFW-1:0]    out_lane_r;
  logic              out_last_r;
  logic [kwsrm_pkg::MASK_FW-1:0] out_mask_r;
  logic              out_done_r;

  logic              acc;
  logic [LANE_W-1:0] in_lane;
  logic              item_ok;
  logic [LANES-1:0]  wait_vec;
  logic              others_wait;
  logic              slot_free;
  logic              load_rec;
  logic              load_done;
  logic              ram_we;
  logic [LANE_W-1:0] ram_raddr;
  logic [RAM_W-1:0]  ram_rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_value;
  logic [LANE_W-1:0] emit_sel;
  kwsrm_pkg::cmp_res_t cmp_res;

  assign in_lane   = in_bus.lane[LANE_W-1:0];
  assign acc       = in_bus.valid && in_bus.ready;
  assign slot_free = !out_valid_r || out_bus.ready;
  assign rd_key    = ram_rdata[RAM_W-1:VAL_W];
  assign rd_value  = ram_rdata[VAL_W-1:0];
  assign emit_sel  = mode_r ? pick_r : kwsrm_pkg::lowest_set(rem_r);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      wait_vec[i] = status_r[i] == kwsrm_pkg::LS_WAIT;
    end
  end

  assign item_ok = !done_r && (int'(in_bus.lane) < LANES) &&
                   (status_r[in_lane] == kwsrm_pkg::LS_WAIT);
  assign others_wait = |(wait_vec & ~(LANES'(1) << in_lane));

  kwsrm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (LANES)
  ) u_heads (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_lane),
    .wdata ({in_bus.rec_key[KEY_W-1:0], in_bus.rec_value[VAL_W-1:0]}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kwsrm_cmp u_cmp (
    .key   (rd_key),
    .least (least_r),
    .res   (cmp_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kwsrm_pkg::ST_IDLE: begin
        if (acc && item_ok) begin
          if (in_bus.run_ended && (cnt_r == CNT_W'(LANES - 1))) begin
            state_nxt = kwsrm_pkg::ST_DONE;
          end else if (!others_wait) begin
            state_nxt = kwsrm_pkg::ST_SCAN_RD;
          end
        end
      end
      kwsrm_pkg::ST_SCAN_RD: begin
        state_nxt = kwsrm_pkg::ST_SCAN_CMP;
      end
      kwsrm_pkg::ST_SCAN_CMP: begin
        if (scan_idx_r == LANE_W'(LANES - 1)) begin
          state_nxt = kwsrm_pkg::ST_EMIT_RD;
        end else begin
          state_nxt = kwsrm_pkg::ST_SCAN_RD;
        end
      end
      kwsrm_pkg::ST_EMIT_RD: begin
        state_nxt = kwsrm_pkg::ST_EMIT_WR;
      end
      kwsrm_pkg::ST_EMIT_WR: begin
        if (slot_free) begin
          state_nxt = emit_last_r ? kwsrm_pkg::ST_IDLE : kwsrm_pkg::ST_EMIT_RD;
        end
      end
      kwsrm_pkg::ST_DONE: begin
        if (slot_free) begin
          state_nxt = kwsrm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kwsrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_bus.ready  = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = scan_idx_r;
    load_rec      = 1'b0;
    load_done     = 1'b0;
    unique case (state_r)
      kwsrm_pkg::ST_IDLE: begin
        in_bus.ready = 1'b1;
        ram_we       = in_bus.valid && item_ok && !in_bus.run_ended;
      end
      kwsrm_pkg::ST_SCAN_RD, kwsrm_pkg::ST_SCAN_CMP: begin
        ram_raddr = scan_idx_r;
      end
      kwsrm_pkg::ST_EMIT_RD: begin
        ram_raddr = emit_sel;
      end
      kwsrm_pkg::ST_EMIT_WR: begin
        ram_raddr = emit_lane_r;
        load_rec  = slot_free;
      end
      kwsrm_pkg::ST_DONE: begin
        load_done = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      status_nxt[i] = status_r[i];
    end
    cnt_nxt       = cnt_r;
    done_nxt      = done_r || load_done;
    scan_idx_nxt  = scan_idx_r;
    have_nxt      = have_r;
    least_nxt     = least_r;
    pick_nxt      = pick_r;
    match_nxt     = match_r;
    rem_nxt       = rem_r;
    emit_lane_nxt = emit_lane_r;
    emit_last_nxt = emit_last_r;

    if ((state_r == kwsrm_pkg::ST_IDLE) && acc && item_ok) begin
      if (in_bus.run_ended) begin
        status_nxt[in_lane] = kwsrm_pkg::LS_ENDED;
        cnt_nxt             = cnt_r + CNT_W'(1);
      end else begin
        status_nxt[in_lane] = kwsrm_pkg::LS_HEAD;
      end
      scan_idx_nxt = '0;
      have_nxt     = 1'b0;
    end

    if (state_r == kwsrm_pkg::ST_SCAN_CMP) begin
      if (status_r[scan_idx_r] == kwsrm_pkg::LS_HEAD) begin
        if (!have_r || cmp_res.lt) begin
          least_nxt = rd_key;
          pick_nxt  = scan_idx_r;
          match_nxt = LANES'(1) << scan_idx_r;
        end else if (cmp_res.eq) begin
          pick_nxt  = scan_idx_r;
          match_nxt = match_r | (LANES'(1) << scan_idx_r);
        end
        have_nxt = 1'b1;
      end
      scan_idx_nxt = scan_idx_r + LANE_W'(1);
      if (scan_idx_r == LANE_W'(LANES - 1)) begin
        rem_nxt = match_nxt;
        for (int i = 0; i < LANES; i++) begin
          if (match_nxt[i]) begin
            status_nxt[i] = kwsrm_pkg::LS_WAIT;
          end
        end
      end
    end

    if (state_r == kwsrm_pkg::ST_EMIT_RD) begin
      emit_lane_nxt = emit_sel;
      emit_last_nxt = mode_r || (emit_sel == pick_r);
    end

    if (load_rec) begin
      rem_nxt = rem_r & ~(LANES'(1) << emit_lane_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kwsrm_pkg::ST_IDLE;
      for (int i = 0; i < LANES; i++) begin
        status_r[i] <= kwsrm_pkg::LS_WAIT;
      end
      cnt_r       <= '0;
      done_r      <= 1'b0;
      mode_r      <= 1'b0;
      have_r      <= 1'b0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      for (int i = 0; i < LANES; i++) begin
        status_r[i] <= status_nxt[i];
      end
      cnt_r      <= cnt_nxt;
      done_r     <= done_nxt;
      have_r     <= have_nxt;
      scan_idx_r <= scan_idx_nxt;
      if (cfg_bus.valid) begin
        mode_r <= cfg_bus.merge_mode;
      end
      if (load_rec || load_done) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    least_r     <= least_nxt;
    pick_r      <= pick_nxt;
    match_r     <= match_nxt;
    rem_r       <= rem_nxt;
    emit_lane_r <= emit_lane_nxt;
    emit_last_r <= emit_last_nxt;
    if (load_rec) begin
      out_key_r   <= KFW'(rd_key);
      out_value_r <= VFW'(rd_value);
      out_lane_r  <= LFW'(emit_lane_r);
      out_last_r  <= emit_last_r;
      out_mask_r  <= kwsrm_pkg::refill_view(match_r);
      out_done_r  <= 1'b0;
    end else if (load_done) begin
      out_key_r   <= '0;
      out_value_r <= '0;
      out_lane_r  <= '0;
      out_last_r  <= 1'b1;
      out_mask_r  <= '0;
      out_done_r  <= 1'b1;
    end
  end

  assign cfg_bus.ready         = 1'b1;
  assign out_bus.valid         = out_valid_r;
  assign out_bus.out_key       = out_key_r;
  assign out_bus.out_value     = out_value_r;
  assign out_bus.source_lane   = out_lane_r;
  assign out_bus.last_of_group = out_last_r;
  assign out_bus.refill_mask   = out_mask_r;
  assign out_bus.all_done      = out_done_r;

  `KWSRM_ASSERT_NEXT(a_done_sticky, done_r, done_r)
  `KWSRM_ASSERT_NOW(a_cnt_range, !done_r && (state_r != kwsrm_pkg::ST_DONE), int'(cnt_r) < LANES)
  `KWSRM_ASSERT_NEXT(a_last_ends, load_rec && emit_last_r, state_r == kwsrm_pkg::ST_IDLE)
  `KWSRM_ASSERT_NOW(a_emit_in_group, state_r == kwsrm_pkg::ST_EMIT_WR, match_r[emit_lane_r])

endmodule

`default_nettype wire
